// ===== hdl/cpri_pkg.sv =====
// shared types and constants for the circle pair relation block
`default_nettype none
package cpri_pkg;

    // configuration register indexes
    localparam logic CFG_COMPARE_TOL = 1'b0;
    localparam logic CFG_CONTAIN_TOL = 1'b1;

    localparam logic [15:0] COMPARE_TOL_RESET = 16'd1;
    localparam logic [29:0] CONTAIN_TOL_RESET = 30'd0;

    typedef struct packed {
        logic signed [30:0] x1;
        logic signed [30:0] y1;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } geom_t;

    typedef struct packed {
        logic disks_overlap;
        logic boundaries_cross;
        logic is_tangent;
        logic first_inside_second;
        logic first_contains_second;
        logic points_valid;
    } flags_t;

    // carried alongside the center distance root
    typedef struct packed {
        geom_t       geom;
        logic [29:0] r1;
        logic [29:0] r2;
        logic [59:0] r1sq;
        logic [63:0] p;
        logic [63:0] q;
    } dist_side_t;

    // carried alongside the foot offset division
    typedef struct packed {
        geom_t       geom;
        flags_t      flags;
        logic [31:0] gap;
        logic [31:0] d;
        logic [59:0] r1sq;
        logic        c_neg;
        logic        ovf;
    } foot_side_t;

    // carried alongside the half chord root
    typedef struct packed {
        geom_t       geom;
        flags_t      flags;
        logic [31:0] gap;
        logic [31:0] d;
        logic [30:0] c_mag;
        logic        c_neg;
    } chord_side_t;

    // carried alongside the point offset divisions
    typedef struct packed {
        logic signed [30:0] x1;
        logic signed [30:0] y1;
        flags_t             flags;
        logic [31:0]        gap;
        logic               neg_fx;
        logic               neg_fy;
        logic               neg_px;
        logic               neg_py;
    } point_side_t;

endpackage
`default_nettype wire

// ===== hdl/cpri_if.sv =====
// request and result channel interfaces
`default_nettype none
interface cpri_circles_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] first_center_x;
    logic signed [30:0] first_center_y;
    logic [29:0]        first_radius;
    logic signed [30:0] second_center_x;
    logic signed [30:0] second_center_y;
    logic [29:0]        second_radius;

    modport source (
        output valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        output ready
    );
endinterface

interface cpri_relation_if;
    logic               valid;
    logic               ready;
    logic               disks_overlap;
    logic               boundaries_cross;
    logic               is_tangent;
    logic               first_inside_second;
    logic               first_contains_second;
    logic               points_valid;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic [31:0]        boundary_gap;

    modport source (
        output valid, disks_overlap, boundaries_cross, is_tangent,
               first_inside_second, first_contains_second, points_valid,
               point_a_x, point_a_y, point_b_x, point_b_y, boundary_gap,
        input  ready
    );
    modport sink (
        input  valid, disks_overlap, boundaries_cross, is_tangent,
               first_inside_second, first_contains_second, points_valid,
               point_a_x, point_a_y, point_b_x, point_b_y, boundary_gap,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/circle_pair_relation_intersection.sv =====
// circle pair relation and intersection points, fully pipelined
// throughput: one request per cycle; set by the bit-per-stage root and divider pipelines
// a stalled result holds the whole pipeline; ready is low only while a result waits
// reset: asynchronous active low, empties the pipeline and restores the tolerances
`default_nettype none
module circle_pair_relation_intersection (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [29:0] cfg_data,
    cpri_circles_if.sink     circles,
    cpri_relation_if.source  relation
);
    logic [15:0] compare_tol_reg;
    logic [29:0] contain_tol_reg;
    logic        adv;
    logic        out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_tol_reg <= cpri_pkg::COMPARE_TOL_RESET;
            contain_tol_reg <= cpri_pkg::CONTAIN_TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpri_pkg::CFG_COMPARE_TOL: compare_tol_reg <= cfg_data[15:0];
                cpri_pkg::CFG_CONTAIN_TOL: contain_tol_reg <= cfg_data;
                default:                   compare_tol_reg <= compare_tol_reg;
            endcase
        end
    end

    // whole pipeline moves unless a result waits
    assign adv           = !out_valid_reg || relation.ready;
    assign circles.ready = adv;

    // stage 1: center deltas
    logic               s1_v_reg;
    cpri_pkg::geom_t    s1_geom_reg;
    logic [29:0]        s1_r1_reg;
    logic [29:0]        s1_r2_reg;
    cpri_pkg::geom_t    s1_geom_next;

    always_comb
    begin
        s1_geom_next.x1 = circles.first_center_x;
        s1_geom_next.y1 = circles.first_center_y;
        s1_geom_next.dx = 32'(circles.second_center_x) - 32'(circles.first_center_x);
        s1_geom_next.dy = 32'(circles.second_center_y) - 32'(circles.first_center_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= circles.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_geom_reg <= s1_geom_next;
            s1_r1_reg   <= circles.first_radius;
            s1_r2_reg   <= circles.second_radius;
        end
    end

    // stage 2: squares
    logic               s2_v_reg;
    cpri_pkg::geom_t    s2_geom_reg;
    logic [29:0]        s2_r1_reg;
    logic [29:0]        s2_r2_reg;
    logic [62:0]        s2_dxsq_reg;
    logic [62:0]        s2_dysq_reg;
    logic [59:0]        s2_r1sq_reg;
    logic [59:0]        s2_r2sq_reg;
    logic signed [63:0] dxsq_full;
    logic signed [63:0] dysq_full;

    assign dxsq_full = s1_geom_reg.dx * s1_geom_reg.dx;
    assign dysq_full = s1_geom_reg.dy * s1_geom_reg.dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_geom_reg <= s1_geom_reg;
            s2_r1_reg   <= s1_r1_reg;
            s2_r2_reg   <= s1_r2_reg;
            s2_dxsq_reg <= dxsq_full[62:0];
            s2_dysq_reg <= dysq_full[62:0];
            s2_r1sq_reg <= s1_r1_reg * s1_r1_reg;
            s2_r2sq_reg <= s1_r2_reg * s1_r2_reg;
        end
    end

    // stage 3: squared distance and power terms
    logic                 s3_v_reg;
    logic [63:0]          s3_dsq_reg;
    cpri_pkg::dist_side_t s3_side_reg;
    logic [63:0]          dsq_next;
    cpri_pkg::dist_side_t s3_side_next;

    always_comb
    begin
        dsq_next            = 64'(s2_dxsq_reg) + 64'(s2_dysq_reg);
        s3_side_next.geom   = s2_geom_reg;
        s3_side_next.r1     = s2_r1_reg;
        s3_side_next.r2     = s2_r2_reg;
        s3_side_next.r1sq   = s2_r1sq_reg;
        s3_side_next.p      = 64'(s2_dxsq_reg) + 64'(s2_dysq_reg) + 64'(s2_r1sq_reg);
        s3_side_next.q      = 64'(s2_r2sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_dsq_reg  <= dsq_next;
            s3_side_reg <= s3_side_next;
        end
    end

    // center distance root
    logic                 rd_v;
    logic [31:0]          rd_d;
    cpri_pkg::dist_side_t rd_side;

    cpri_sqrt_pipe #(
        .W      (64),
        .side_t (cpri_pkg::dist_side_t)
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_v_reg),
        .in_rad    (s3_dsq_reg),
        .in_side   (s3_side_reg),
        .out_valid (rd_v),
        .out_root  (rd_d),
        .out_side  (rd_side)
    );

    // stage f1: relation flags, gap and foot offset numerator
    logic                 f1_v_reg;
    cpri_pkg::foot_side_t f1_side_reg;
    logic [63:0]          f1_diff_reg;
    logic [32:0]          f1_den_reg;
    cpri_pkg::foot_side_t f1_side_next;
    logic signed [34:0]   sd, se, ssum, sad, sr1, sr2, sct, sgap;
    logic                 apart;

    always_comb
    begin
        sd    = 35'(rd_d);
        se    = 35'(compare_tol_reg);
        sr1   = 35'(rd_side.r1);
        sr2   = 35'(rd_side.r2);
        sct   = 35'(contain_tol_reg);
        ssum  = sr1 + sr2;
        sad   = (sr1 >= sr2) ? (sr1 - sr2) : (sr2 - sr1);
        sgap  = (sd >= ssum) ? (sd - ssum) : (ssum - sd);
        apart = ssum < (sd - se);

        f1_side_next.geom = rd_side.geom;
        f1_side_next.d    = rd_d;
        f1_side_next.r1sq = rd_side.r1sq;
        f1_side_next.c_neg = rd_side.p < rd_side.q;
        f1_side_next.ovf  = 1'b0;
        f1_side_next.gap  = (sgap > 35'sh0FFFFFFFF) ? 32'hFFFFFFFF : sgap[31:0];

        f1_side_next.flags.disks_overlap    = !apart;
        f1_side_next.flags.boundaries_cross = (sd > sad + se) && (sd < ssum - se);
        f1_side_next.flags.is_tangent       = ((ssum - sd <= se) && (sd - ssum <= se))
                                            || ((sad - sd <= se) && (sd - sad <= se));
        f1_side_next.flags.first_inside_second   = (sr2 - sr1) > (sd + se);
        f1_side_next.flags.first_contains_second = sr1 >= (sr2 + sd - sct);
        f1_side_next.flags.points_valid = !apart && !(sad > sd + se)
                                        && !((sad <= se) && (sd <= se)) && (rd_d != 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_v_reg <= 1'b0;
        else if (adv)
            f1_v_reg <= rd_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_side_reg <= f1_side_next;
            f1_diff_reg <= (rd_side.p >= rd_side.q) ? (rd_side.p - rd_side.q)
                                                    : (rd_side.q - rd_side.p);
            f1_den_reg  <= (rd_d == 32'd0) ? 33'd2 : {rd_d, 1'b0};
        end
    end

    // stage f2: quotient overflow check
    logic                 f2_v_reg;
    cpri_pkg::foot_side_t f2_side_reg;
    logic [63:0]          f2_num_reg;
    logic [32:0]          f2_den_reg;
    logic                 ovf;
    cpri_pkg::foot_side_t f2_side_next;

    assign ovf = {1'b0, f1_diff_reg} >= (65'(f1_den_reg) << 31);

    always_comb
    begin
        f2_side_next     = f1_side_reg;
        f2_side_next.ovf = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_v_reg <= 1'b0;
        else if (adv)
            f2_v_reg <= f1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_side_reg <= f2_side_next;
            f2_num_reg  <= ovf ? 64'd0 : f1_diff_reg;
            f2_den_reg  <= f1_den_reg;
        end
    end

    // foot offset division
    logic                 cd_v;
    logic [30:0]          cd_quo;
    cpri_pkg::foot_side_t cd_side;

    cpri_div_pipe #(
        .NW     (64),
        .DW     (33),
        .QB     (31),
        .side_t (cpri_pkg::foot_side_t)
    ) u_foot_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f2_v_reg),
        .in_num    (f2_num_reg),
        .in_den    (f2_den_reg),
        .in_side   (f2_side_reg),
        .out_valid (cd_v),
        .out_quo   (cd_quo),
        .out_side  (cd_side)
    );

    // stage c: saturated foot offset
    logic                 c_v_reg;
    cpri_pkg::foot_side_t c_side_reg;
    logic [30:0]          c_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (adv)
            c_v_reg <= cd_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= cd_side;
            c_mag_reg  <= cd_side.ovf ? 31'h7FFFFFFF : cd_quo;
        end
    end

    // stage csq: foot offset squared
    logic                 csq_v_reg;
    cpri_pkg::foot_side_t csq_side_reg;
    logic [30:0]          csq_mag_reg;
    logic [61:0]          csq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            csq_v_reg <= 1'b0;
        else if (adv)
            csq_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            csq_side_reg <= c_side_reg;
            csq_mag_reg  <= c_mag_reg;
            csq_reg      <= c_mag_reg * c_mag_reg;
        end
    end

    // stage hs: half chord squared, clamped at zero
    logic                  hs_v_reg;
    logic [59:0]           hs_reg;
    cpri_pkg::chord_side_t hs_side_reg;
    cpri_pkg::chord_side_t hs_side_next;

    always_comb
    begin
        hs_side_next.geom  = csq_side_reg.geom;
        hs_side_next.flags = csq_side_reg.flags;
        hs_side_next.gap   = csq_side_reg.gap;
        hs_side_next.d     = csq_side_reg.d;
        hs_side_next.c_mag = csq_mag_reg;
        hs_side_next.c_neg = csq_side_reg.c_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hs_v_reg <= 1'b0;
        else if (adv)
            hs_v_reg <= csq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hs_side_reg <= hs_side_next;
            hs_reg      <= (62'(csq_side_reg.r1sq) > csq_reg)
                         ? 60'(62'(csq_side_reg.r1sq) - csq_reg) : 60'd0;
        end
    end

    // half chord root
    logic                  rh_v;
    logic [29:0]           rh_h;
    cpri_pkg::chord_side_t rh_side;

    cpri_sqrt_pipe #(
        .W      (60),
        .side_t (cpri_pkg::chord_side_t)
    ) u_chord_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (hs_v_reg),
        .in_rad    (hs_reg),
        .in_side   (hs_side_reg),
        .out_valid (rh_v),
        .out_root  (rh_h),
        .out_side  (rh_side)
    );

    // stage prod: offset products ahead of the four divisions
    logic                  pr_v_reg;
    logic [62:0]           pr_fx_reg, pr_fy_reg, pr_px_reg, pr_py_reg;
    logic [31:0]           pr_d_reg;
    cpri_pkg::point_side_t pr_side_reg;
    cpri_pkg::point_side_t pr_side_next;
    logic [31:0]           adx, ady;
    logic                  c_is_neg;

    always_comb
    begin
        adx      = rh_side.geom.dx[31] ? 32'(-rh_side.geom.dx) : 32'(rh_side.geom.dx);
        ady      = rh_side.geom.dy[31] ? 32'(-rh_side.geom.dy) : 32'(rh_side.geom.dy);
        c_is_neg = rh_side.c_neg && (rh_side.c_mag != 31'd0);
        pr_side_next.x1     = rh_side.geom.x1;
        pr_side_next.y1     = rh_side.geom.y1;
        pr_side_next.flags  = rh_side.flags;
        pr_side_next.gap    = rh_side.gap;
        pr_side_next.neg_fx = c_is_neg ^ rh_side.geom.dx[31];
        pr_side_next.neg_fy = c_is_neg ^ rh_side.geom.dy[31];
        pr_side_next.neg_px = rh_side.geom.dy[31];
        pr_side_next.neg_py = rh_side.geom.dx[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_v_reg <= 1'b0;
        else if (adv)
            pr_v_reg <= rh_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_side_reg <= pr_side_next;
            pr_fx_reg   <= rh_side.c_mag * adx;
            pr_fy_reg   <= rh_side.c_mag * ady;
            pr_px_reg   <= 63'(rh_h * ady);
            pr_py_reg   <= 63'(rh_h * adx);
            pr_d_reg    <= (rh_side.d == 32'd0) ? 32'd1 : rh_side.d;
        end
    end

    // four offset divisions by the center distance
    logic                  pd_v;
    cpri_pkg::point_side_t pd_side;
    logic [30:0]           q_fx, q_fy, q_px, q_py;
    logic                  unused_v_fy, unused_v_px, unused_v_py;
    logic                  unused_s_fy, unused_s_px, unused_s_py;

    cpri_div_pipe #(
        .NW (63), .DW (32), .QB (31), .side_t (cpri_pkg::point_side_t)
    ) u_fx_div (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (pr_v_reg),
        .in_num (pr_fx_reg), .in_den (pr_d_reg), .in_side (pr_side_reg),
        .out_valid (pd_v), .out_quo (q_fx), .out_side (pd_side)
    );

    cpri_div_pipe #(
        .NW (63), .DW (32), .QB (31), .side_t (logic)
    ) u_fy_div (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (pr_v_reg),
        .in_num (pr_fy_reg), .in_den (pr_d_reg), .in_side (1'b0),
        .out_valid (unused_v_fy), .out_quo (q_fy), .out_side (unused_s_fy)
    );

    cpri_div_pipe #(
        .NW (63), .DW (32), .QB (31), .side_t (logic)
    ) u_px_div (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (pr_v_reg),
        .in_num (pr_px_reg), .in_den (pr_d_reg), .in_side (1'b0),
        .out_valid (unused_v_px), .out_quo (q_px), .out_side (unused_s_px)
    );

    cpri_div_pipe #(
        .NW (63), .DW (32), .QB (31), .side_t (logic)
    ) u_py_div (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (pr_v_reg),
        .in_num (pr_py_reg), .in_den (pr_d_reg), .in_side (1'b0),
        .out_valid (unused_v_py), .out_quo (q_py), .out_side (unused_s_py)
    );

    // output stage: point sums with saturation
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh07FFFFFFF)
            r = 32'h7FFFFFFF;
        else if (v < -34'sh080000000)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [33:0] apply_sign(input logic [30:0] m, input logic n);
        logic signed [33:0] t;
        t = 34'(m);
        return n ? -t : t;
    endfunction

    logic signed [33:0] ox1, oy1, sfx, sfy, spx, spy;
    logic               pv;
    cpri_pkg::flags_t   out_flags_reg;
    logic [31:0]        ax_reg, ay_reg, bx_reg, by_reg, gap_reg;

    always_comb
    begin
        ox1 = 34'(pd_side.x1);
        oy1 = 34'(pd_side.y1);
        sfx = apply_sign(q_fx, pd_side.neg_fx);
        sfy = apply_sign(q_fy, pd_side.neg_fy);
        spx = apply_sign(q_px, pd_side.neg_px);
        spy = apply_sign(q_py, pd_side.neg_py);
        pv  = pd_side.flags.points_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= pd_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_flags_reg <= pd_side.flags;
            gap_reg       <= pd_side.gap;
            ax_reg        <= pv ? sat32(ox1 + sfx - spx) : 32'd0;
            ay_reg        <= pv ? sat32(oy1 + sfy + spy) : 32'd0;
            bx_reg        <= pv ? sat32(ox1 + sfx + spx) : 32'd0;
            by_reg        <= pv ? sat32(oy1 + sfy - spy) : 32'd0;
        end
    end

    assign relation.valid                 = out_valid_reg;
    assign relation.disks_overlap         = out_flags_reg.disks_overlap;
    assign relation.boundaries_cross      = out_flags_reg.boundaries_cross;
    assign relation.is_tangent            = out_flags_reg.is_tangent;
    assign relation.first_inside_second   = out_flags_reg.first_inside_second;
    assign relation.first_contains_second = out_flags_reg.first_contains_second;
    assign relation.points_valid          = out_flags_reg.points_valid;
    assign relation.point_a_x             = ax_reg;
    assign relation.point_a_y             = ay_reg;
    assign relation.point_b_x             = bx_reg;
    assign relation.point_b_y             = by_reg;
    assign relation.boundary_gap          = gap_reg;
endmodule
`default_nettype wire

// ===== hdl/cpri_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module cpri_sqrt_pipe #(
    parameter int  W      = 64,
    parameter type side_t = logic
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [W-1:0]   in_rad,
    input  wire side_t          in_side,
    output logic                out_valid,
    output logic [W/2-1:0]      out_root,
    output side_t               out_side
);
    localparam int N = W / 2;

    logic [W-1:0] rem_reg  [N];
    logic [W-1:0] root_reg [N];
    side_t        side_reg [N];
    logic [N-1:0] vld_reg;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [W:0] BITV = (W+1)'(1) << (W - 2 - 2 * k);
        logic [W-1:0] rem_in;
        logic [W-1:0] root_in;
        side_t        side_in;
        logic         vld_in;
        logic [W:0]   trial;

        if (k == 0) begin : g_first
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = {1'b0, root_in} + BITV;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        // one restoring root step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[k]  <= W'({1'b0, rem_in} - trial);
                    root_reg[k] <= (root_in >> 1) + BITV[W-1:0];
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1][W/2-1:0];
    assign out_side  = side_reg[N-1];
endmodule
`default_nettype wire

// ===== hdl/cpri_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module cpri_div_pipe #(
    parameter int  NW     = 64,
    parameter int  DW     = 33,
    parameter int  QB     = 31,
    parameter type side_t = logic
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire side_t         in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quo,
    output side_t              out_side
);
    logic [NW-1:0] rem_reg  [QB];
    logic [DW-1:0] den_reg  [QB];
    logic [QB-1:0] quo_reg  [QB];
    side_t         side_reg [QB];
    logic [QB-1:0] vld_reg;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [NW-1:0]    rem_in;
        logic [DW-1:0]    den_in;
        logic [QB-1:0]    quo_in;
        side_t            side_in;
        logic             vld_in;
        logic [NW+DW-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = (NW+DW)'(den_in) << SH;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        // compare and subtract the shifted divisor
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                den_reg[k]  <= den_in;
                if ((NW+DW)'(rem_in) >= trial)
                begin
                    rem_reg[k] <= NW'((NW+DW)'(rem_in) - trial);
                    quo_reg[k] <= quo_in | (QB'(1) << SH);
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= quo_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_side  = side_reg[QB-1];
endmodule
`default_nettype wire

// ===== hdl/cpri_checker.sv =====
// result channel checks, bound to the top level
`default_nettype none
module cpri_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        disks_overlap,
    input wire logic        boundaries_cross,
    input wire logic        points_valid,
    input wire logic [31:0] point_a_x,
    input wire logic [31:0] point_a_y,
    input wire logic [31:0] point_b_x,
    input wire logic [31:0] point_b_y
);
    // a waiting result stays valid and keeps point_a_x and point_b_y
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(point_a_x) && $stable(point_b_y))
        else $error("result changed while stalled");

    // no points means zero point fields
    a_zero_pts: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !points_valid |-> point_a_x == 32'd0 && point_a_y == 32'd0
                                   && point_b_x == 32'd0 && point_b_y == 32'd0)
        else $error("point fields not cleared");

    // crossing boundaries always give points
    a_cross_pts: assert property (@(posedge clk) disable iff (!rst_n)
        valid && boundaries_cross |-> points_valid)
        else $error("crossing without points");

    // points only when disks overlap
    a_pts_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && points_valid |-> disks_overlap)
        else $error("points for apart disks");
endmodule

bind circle_pair_relation_intersection cpri_checker u_cpri_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid            (relation.valid),
    .ready            (relation.ready),
    .disks_overlap    (relation.disks_overlap),
    .boundaries_cross (relation.boundaries_cross),
    .points_valid     (relation.points_valid),
    .point_a_x        (relation.point_a_x),
    .point_a_y        (relation.point_a_y),
    .point_b_x        (relation.point_b_x),
    .point_b_y        (relation.point_b_y)
);
`default_nettype wire
